@@ rtl/core/stop_bit_integer_encoder_assert.svh @@
// Assertion macros shared by the encoder modules.
`ifndef STOP_BIT_INTEGER_ENCODER_ASSERT_SVH
`define STOP_BIT_INTEGER_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SBE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sbe assertion failed");
`define SBE_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`else
`define SBE_ASSERT(label, clk, rst_n, prop)
`define SBE_ASSERT_MSG(label, clk, rst_n, prop, msg)
`endif

`endif

@@ rtl/core/sbe_pkg.sv @@
`default_nettype none

package sbe_pkg;

	localparam int VALUE_W    = 64;
	localparam int GROUP_W    = 7;
	localparam int MAX_GROUPS = 10;
	localparam int IDX_W      = $clog2(MAX_GROUPS);
	localparam int EXT_W      = GROUP_W * MAX_GROUPS;

	localparam logic [6:0] GROUP_MASK = 7'h7f;
	localparam logic [7:0] STOP_BIT   = 8'h80;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_signed;
	} sbe_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} sbe_out_t;

	typedef struct packed {
		logic load;
		logic step;
	} sbe_cmd_t;

	typedef struct packed {
		logic idx_zero;
	} sbe_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/stop_bit_integer_encoder.sv @@
// Flow: an accepted request is loaded in IDLE; then each step in BUSY moves one group into the
//   output register, n = 1..10 bytes, one byte per cycle out of the datapath's group selector
//   while the output register is free; the next request is taken while the final
//   byte still waits in the output register.
// Reset: arst_n clears the controller state, the output valid and the group index; value and byte are not reset.
`default_nettype none

module stop_bit_integer_encoder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire sbe_pkg::sbe_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sbe_pkg::sbe_out_t     out_data
);
	import sbe_pkg::*;

	sbe_cmd_t cmd;
	sbe_sts_t sts;

	sbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbe_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);
endmodule

`default_nettype wire

@@ rtl/core/sbe_dp.sv @@
`default_nettype none
`include "stop_bit_integer_encoder_assert.svh"

module sbe_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbe_pkg::sbe_in_t  in_data,
	input  wire sbe_pkg::sbe_cmd_t cmd,
	output sbe_pkg::sbe_sts_t      sts,
	output sbe_pkg::sbe_out_t      out_data
);
	import sbe_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               sgn_q;
	logic [IDX_W-1:0]   idx_q;
	sbe_out_t           out_q;

	logic [IDX_W-1:0]      cnt_m1;
	logic [MAX_GROUPS-1:0] fits;
	logic [EXT_W-1:0]      ext;
	logic [GROUP_W-1:0]    grp;

	// Group n fits when everything above its top bit is pure extension.
	always_comb begin
		logic [VALUE_W-1:0] sh;
		fits   = '0;
		cnt_m1 = IDX_W'(MAX_GROUPS - 1);
		for (int n = 1; n < MAX_GROUPS; n++) begin
			if (in_data.is_signed) begin
				sh      = VALUE_W'($signed(in_data.value) >>> (GROUP_W * n - 1));
				fits[n] = (&sh) | ~(|sh);
			end else begin
				sh      = in_data.value >> (GROUP_W * n);
				fits[n] = ~(|sh);
			end
		end
		for (int n = MAX_GROUPS - 1; n >= 1; n--) begin
			if (fits[n]) begin
				cnt_m1 = IDX_W'(n - 1);
			end
		end
	end

	assign ext = {{(EXT_W - VALUE_W){sgn_q & value_q[VALUE_W-1]}}, value_q};
	assign grp = ext[int'(idx_q) * GROUP_W +: GROUP_W] & GROUP_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= cnt_m1;
		end else if (cmd.step && idx_q != '0) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_data.value;
			sgn_q   <= in_data.is_signed;
		end
		if (cmd.step) begin
			out_q.out_byte <= (idx_q == '0) ? ({1'b0, grp} | STOP_BIT) : {1'b0, grp};
			out_q.last     <= (idx_q == '0);
		end
	end

	assign sts.idx_zero = (idx_q == '0);
	assign out_data     = out_q;

	`SBE_ASSERT(a_idx_range, clk, arst_n, cmd.load |=> idx_q <= IDX_W'(MAX_GROUPS - 1))
	`SBE_ASSERT(a_last_on_zero, clk, arst_n, cmd.step |=> out_q.last == ($past(idx_q) == '0))
	`SBE_ASSERT_MSG(a_stop_bit, clk, arst_n, cmd.step |=> out_q.out_byte[7] == out_q.last,
		"stop bit disagrees with last flag")
endmodule

`default_nettype wire

@@ rtl/core/sbe_ctrl.sv @@
`default_nettype none
`include "stop_bit_integer_encoder_assert.svh"

module sbe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire sbe_pkg::sbe_sts_t sts,
	output sbe_pkg::sbe_cmd_t      cmd
);
	import sbe_pkg::*;

	localparam logic IDLE = 1'b0;
	localparam logic BUSY = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q == BUSY);
	assign cmd.load  = in_valid && (state_q == IDLE);
	assign cmd.step  = (state_q == BUSY) && slot_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (cmd.load) begin
						state_q <= BUSY;
					end
				end
				BUSY: begin
					// drop back once the final byte moves into the output register
					if (cmd.step && sts.idx_zero) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SBE_ASSERT(a_load_busy, clk, arst_n, cmd.load |=> state_q == BUSY)
	`SBE_ASSERT(a_step_busy, clk, arst_n, cmd.step |-> state_q == BUSY)
	`SBE_ASSERT(a_final_idle, clk, arst_n, (cmd.step && sts.idx_zero) |=> state_q == IDLE)
endmodule

`default_nettype wire

@@ verif/stop_bit_integer_encoder_tb.sv @@
`timescale 1ns / 1ps

module stop_bit_integer_encoder_tb;
	import sbe_pkg::*;

	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM   = 250;

	// Rows with a nonzero byte count carry their encoding inline, the first byte
	// leftmost in the low byte_count bytes; the rest go through the predictor.
	typedef struct packed {
		logic [63:0] value;
		logic        is_signed;
		logic [3:0]  byte_count;
		logic [79:0] bytes;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{64'h0000_0000_0000_0000, 1'b0, 4'd1,  80'h80},
		'{64'h0000_0000_0000_0000, 1'b1, 4'd1,  80'h80},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd1,  80'hFF},
		'{64'h0000_0000_0000_007F, 1'b0, 4'd1,  80'hFF},
		'{64'h0000_0000_0000_0080, 1'b0, 4'd2,  80'h0180},
		'{64'h0000_0000_0000_003F, 1'b1, 4'd1,  80'hBF},
		'{64'h0000_0000_0000_0040, 1'b1, 4'd2,  80'h00C0},
		'{64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 4'd1,  80'hC0},
		'{64'hFFFF_FFFF_FFFF_FFBF, 1'b1, 4'd2,  80'h7FBF},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd10, 80'h01_7F7F7F7F_7F7F7F7F_FF},
		'{64'h8000_0000_0000_0000, 1'b0, 4'd10, 80'h01_00000000_00000000_80},
		'{64'h8000_0000_0000_0000, 1'b1, 4'd10, 80'h7F_00000000_00000000_80},
		'{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd10, 80'h00_7F7F7F7F_7F7F7F7F_FF},
		'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 4'd9,  80'h7F7F7F7F_7F7F7F7F_FF},
		'{64'h0000_0000_FFFF_FFFF, 1'b0, 4'd0,  80'h0},
		'{64'hFFFF_FFFF_8000_0000, 1'b1, 4'd0,  80'h0},
		'{64'h0000_0000_7FFF_FFFF, 1'b1, 4'd0,  80'h0},
		'{64'h0100_0000_0000_0000, 1'b0, 4'd0,  80'h0},
		'{64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 4'd0,  80'h0},
		'{64'h5A5A_A5A5_F0F0_0F0F, 1'b1, 4'd0,  80'h0},
		'{64'h0000_0000_0000_3FFF, 1'b0, 4'd0,  80'h0},
		'{64'h0000_0000_0000_4000, 1'b0, 4'd0,  80'h0}
	};

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	sbe_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	sbe_out_t out_data;

	sbe_out_t    expected_bytes [$];
	int unsigned bytes_checked = 0;
	int unsigned mismatches    = 0;
	logic        calm;

	stop_bit_integer_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAIL stop_bit_integer_encoder");
		$finish;
	end

	// Widen to ten groups by sign or zeros, find the shortest form, emit top group first.
	function automatic void predict_stop_bit_bytes(input logic [63:0] value, input logic sgn);
		logic signed [69:0] widened;
		logic [69:0]        upper;
		int                 groups;
		int                 k;
		sbe_out_t           b;
		widened = sgn ? {{6{value[63]}}, value} : {6'b0, value};
		groups = MAX_GROUPS;
		for (k = MAX_GROUPS - 1; k >= 1; k--) begin
			upper = widened >>> (GROUP_W * k - 1);
			if (sgn ? (upper == '0 || upper == '1) : ((widened >> (GROUP_W * k)) == '0))
				groups = k;
		end
		for (k = groups - 1; k >= 0; k--) begin
			b.last = (k == 0);
			b.out_byte = {b.last, widened[GROUP_W * k +: GROUP_W]};
			expected_bytes.push_back(b);
		end
	endfunction

	function automatic sbe_in_t random_request();
		sbe_in_t            r;
		logic signed [63:0] raised;
		int unsigned        pad;
		r.value = {$urandom(), $urandom()};
		r.is_signed = 1'($urandom_range(0, 1));
		pad = $urandom_range(0, 63);
		raised = r.value << pad;
		// extend the kept low bits either by sign or by zeros
		if ($urandom_range(0, 1))
			r.value = raised >>> pad;
		else
			r.value = $unsigned(raised) >> pad;
		return r;
	endfunction

	task automatic offer_request(input sbe_in_t req, input int unsigned byte_count,
			input logic [79:0] bytes);
		sbe_out_t    b;
		int unsigned i;
		if (!calm && $urandom_range(0, 99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		if (byte_count == 0) begin
			predict_stop_bit_bytes(req.value, req.is_signed);
		end else begin
			for (i = 0; i < byte_count; i++) begin
				b.out_byte = bytes[(byte_count - 1 - i) * 8 +: 8];
				b.last = (i == byte_count - 1);
				expected_bytes.push_back(b);
			end
		end
	endtask

	initial begin
		sbe_in_t req;
		int      n;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		calm     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++) begin
			req.value = DIRECTED_ROWS[n].value;
			req.is_signed = DIRECTED_ROWS[n].is_signed;
			offer_request(req, DIRECTED_ROWS[n].byte_count, DIRECTED_ROWS[n].bytes);
		end

		// drain completely before the random part
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);

		for (n = 0; n < N_RANDOM; n++) begin
			calm <= (n >= 100 && n < 160);
			offer_request(random_request(), 0, '0);
		end

		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("PASS stop_bit_integer_encoder");
		else
			$display("FAIL stop_bit_integer_encoder");
		$finish;
	end

	initial begin
		bit          held_off;
		int unsigned hold;
		held_off  = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && bytes_checked >= 150) begin
				// hold the output long enough for the block to back up into its input
				held_off = 1'b1;
				out_stall <= 1'b1;
				for (hold = 0; hold < 120; hold++) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 18);
			end
		end
	end

	always @(posedge clk) begin
		sbe_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte: expected none, got out_byte %h last %b",
					$time, out_data.out_byte, out_data.last);
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					mismatches++;
					$display("%0t: out_byte mismatch: expected %h, got %h",
						$time, want.out_byte, out_data.out_byte);
				end
				if (out_data.last !== want.last) begin
					mismatches++;
					$display("%0t: last mismatch: expected %b, got %b",
						$time, want.last, out_data.last);
				end
			end
		end
	end

endmodule
